[rtl/core/bcfr_pkg.sv]
// Boot command frame receiver: shared types, codes and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bcfr_pkg;

  // Default payload sizes
  localparam int unsigned DEF_PAGE_BYTES   = 1024;
  localparam int unsigned DEF_RECORD_BYTES = 36;

  // Field and state widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned LEFT_W   = 11;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned TO_W     = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LINK_W   = 2;

  // Configuration
  localparam int unsigned        DATA_W       = 32;
  localparam int unsigned        ADDR_W       = 3;
  localparam logic [TO_W-1:0]    TIMEOUT_RESET = 8'd10;
  localparam logic               REG_FIRST_TO = 1'b0;
  localparam logic               REG_IDLE_TO  = 1'b1;

  // Input opcodes
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd2;

  // Link states
  localparam logic [LINK_W-1:0] LS_FIRST   = 2'd0;
  localparam logic [LINK_W-1:0] LS_READY   = 2'd1;
  localparam logic [LINK_W-1:0] LS_PAYLOAD = 2'd2;
  localparam logic [LINK_W-1:0] LS_DONE    = 2'd3;

  // Command bytes
  localparam logic [BYTE_W-1:0] CMD_VERSION = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_START   = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_PAGE    = 8'h03;

  // Store targets
  localparam logic TGT_RECORD = 1'b0;
  localparam logic TGT_PAGE   = 1'b1;

  // Timeout kinds
  localparam logic [KIND_W-1:0] TO_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] TO_FIRST = 2'd1;
  localparam logic [KIND_W-1:0] TO_LATER = 2'd2;

  typedef struct packed {
    logic [TO_W-1:0] idle_timeout;
    logic            first_wr;       // write transfer to first_timeout_ticks
    logic [TO_W-1:0] first_wdata;
  } cfg_t;

  typedef struct packed {
    logic                store_valid;
    logic                store_target;
    logic [OFFSET_W-1:0] store_offset;
    logic [BYTE_W-1:0]   store_byte;
    logic                frame_done;
    logic [BYTE_W-1:0]   frame_command;
    logic [KIND_W-1:0]   timeout_kind;
  } res_t;

endpackage

[rtl/core/bcfr_cfg_regs.sv]
// Boot command frame receiver: APB-style timeout configuration registers.
// Depends on bcfr_pkg.
`timescale 1ns / 1ps

module bcfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcfr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcfr_pkg::DATA_W-1:0]   pwdata,
  output logic [bcfr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bcfr_pkg::cfg_t                cfg_o
);

  logic [bcfr_pkg::TO_W-1:0] first_q, first_d;
  logic [bcfr_pkg::TO_W-1:0] idle_q, idle_d;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    first_d = first_q;
    idle_d  = idle_q;
    if (wr_en) begin
      unique case (reg_sel)
        bcfr_pkg::REG_FIRST_TO: first_d = pwdata[bcfr_pkg::TO_W-1:0];
        bcfr_pkg::REG_IDLE_TO:  idle_d  = pwdata[bcfr_pkg::TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= bcfr_pkg::TIMEOUT_RESET;
      idle_q  <= bcfr_pkg::TIMEOUT_RESET;
    end else begin
      first_q <= first_d;
      idle_q  <= idle_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      bcfr_pkg::REG_FIRST_TO: prdata[bcfr_pkg::TO_W-1:0] = first_q;
      bcfr_pkg::REG_IDLE_TO:  prdata[bcfr_pkg::TO_W-1:0] = idle_q;
      default: ;
    endcase
  end

  assign cfg_o.idle_timeout  = idle_q;
  assign cfg_o.first_wr      = wr_en & (reg_sel == bcfr_pkg::REG_FIRST_TO);
  assign cfg_o.first_wdata   = pwdata[bcfr_pkg::TO_W-1:0];

endmodule

[rtl/core/bcfr_core.sv]
// Boot command frame receiver: link state, payload counters, tick/deadline
// tracking and the per-item result. Depends on bcfr_pkg.
`timescale 1ns / 1ps

module bcfr_core #(
  parameter int unsigned PAGE_BYTES   = bcfr_pkg::DEF_PAGE_BYTES,
  parameter int unsigned RECORD_BYTES = bcfr_pkg::DEF_RECORD_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [bcfr_pkg::OP_W-1:0]     opcode_i,
  input  logic [bcfr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  bcfr_pkg::cfg_t                cfg_i,
  output bcfr_pkg::res_t                res_o
);

  localparam logic [bcfr_pkg::LEFT_W-1:0] PageLeft   = bcfr_pkg::LEFT_W'(PAGE_BYTES);
  localparam logic [bcfr_pkg::LEFT_W-1:0] RecordLeft = bcfr_pkg::LEFT_W'(RECORD_BYTES);

  logic [bcfr_pkg::LINK_W-1:0]   link_q, link_d;
  logic [bcfr_pkg::BYTE_W-1:0]   cmd_q, cmd_d;
  logic [bcfr_pkg::LEFT_W-1:0]   left_q, left_d;
  logic [bcfr_pkg::OFFSET_W-1:0] off_q, off_d;
  logic                          tgt_q, tgt_d;
  logic [bcfr_pkg::TICK_W-1:0]   tick_q, tick_d;
  logic [bcfr_pkg::TICK_W-1:0]   dl_q, dl_d;

  logic [bcfr_pkg::TICK_W-1:0]   tick_inc;
  logic [bcfr_pkg::TICK_W:0]     dl_sum;
  logic                          take_cmd;
  bcfr_pkg::res_t                res;

  assign tick_inc = (&tick_q) ? tick_q : tick_q + 1'b1;
  assign dl_sum   = {1'b0, tick_q}
                  + {{(bcfr_pkg::TICK_W + 1 - bcfr_pkg::TO_W){1'b0}}, cfg_i.idle_timeout};

  always_comb begin
    link_d   = link_q;
    cmd_d    = cmd_q;
    left_d   = left_q;
    off_d    = off_q;
    tgt_d    = tgt_q;
    tick_d   = tick_q;
    dl_d     = dl_q;
    res      = '0;
    take_cmd = 1'b0;

    if (step_i) begin
      case (opcode_i)
        bcfr_pkg::OP_BYTE: begin
          unique case (link_q)
            bcfr_pkg::LS_FIRST:   take_cmd = (rx_byte_i == bcfr_pkg::CMD_VERSION);
            bcfr_pkg::LS_READY:   take_cmd = 1'b1;
            bcfr_pkg::LS_PAYLOAD: begin
              if (left_q == '0) begin
                // empty count: close the frame without storing
                link_d         = bcfr_pkg::LS_DONE;
                res.frame_done = 1'b1;
              end else begin
                res.store_valid  = 1'b1;
                res.store_target = tgt_q;
                res.store_offset = off_q;
                res.store_byte   = rx_byte_i;
                off_d            = off_q + 1'b1;
                left_d           = left_q - 1'b1;
                if (left_q == bcfr_pkg::LEFT_W'(1)) begin
                  link_d         = bcfr_pkg::LS_DONE;
                  res.frame_done = 1'b1;
                end
              end
            end
            bcfr_pkg::LS_DONE: ;
            default: ;
          endcase

          if (take_cmd) begin
            cmd_d = rx_byte_i;
            case (rx_byte_i)
              bcfr_pkg::CMD_START: begin
                tgt_d  = bcfr_pkg::TGT_RECORD;
                left_d = RecordLeft;
                off_d  = '0;
                link_d = bcfr_pkg::LS_PAYLOAD;
              end
              bcfr_pkg::CMD_PAGE: begin
                tgt_d  = bcfr_pkg::TGT_PAGE;
                left_d = PageLeft;
                off_d  = '0;
                link_d = bcfr_pkg::LS_PAYLOAD;
              end
              default: begin
                link_d         = bcfr_pkg::LS_DONE;
                res.frame_done = 1'b1;
              end
            endcase
          end
        end
        bcfr_pkg::OP_TICK: begin
          tick_d = tick_inc;
          if (tick_inc >= dl_q) begin
            res.timeout_kind = (link_q == bcfr_pkg::LS_FIRST) ? bcfr_pkg::TO_FIRST
                                                              : bcfr_pkg::TO_LATER;
          end
        end
        bcfr_pkg::OP_ACK: begin
          if (link_q == bcfr_pkg::LS_DONE) begin
            link_d = bcfr_pkg::LS_READY;
            dl_d   = dl_sum[bcfr_pkg::TICK_W] ? '1 : dl_sum[bcfr_pkg::TICK_W-1:0];
          end
        end
        default: ;
      endcase
    end

    // first-timeout write while waiting for the first command reloads the deadline
    if (cfg_i.first_wr && (link_q == bcfr_pkg::LS_FIRST)) begin
      dl_d = {{(bcfr_pkg::TICK_W - bcfr_pkg::TO_W){1'b0}}, cfg_i.first_wdata};
    end

    res.frame_command = cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= bcfr_pkg::LS_FIRST;
      cmd_q  <= '0;
      left_q <= '0;
      off_q  <= '0;
      tgt_q  <= 1'b0;
      tick_q <= '0;
      dl_q   <= {{(bcfr_pkg::TICK_W - bcfr_pkg::TO_W){1'b0}}, bcfr_pkg::TIMEOUT_RESET};
    end else begin
      link_q <= link_d;
      cmd_q  <= cmd_d;
      left_q <= left_d;
      off_q  <= off_d;
      tgt_q  <= tgt_d;
      tick_q <= tick_d;
      dl_q   <= dl_d;
    end
  end

  assign res_o = res;

endmodule

[rtl/core/boot_command_frame_receiver.sv]
// Boot command frame receiver, top level: input register, state update
// core, result register and configuration port. Depends on bcfr_pkg,
// bcfr_cfg_regs and bcfr_core.
// Throughput: one item per cycle while the result side does not stall; an item passes
// through the input register and then the result register before its result transfer.
// Reset (async, active low): link awaits the first command, both timeout
// registers hold 10, deadline 10, tick count and all counters zero.
`timescale 1ns / 1ps

module boot_command_frame_receiver #(
  parameter int unsigned PAGE_BYTES   = bcfr_pkg::DEF_PAGE_BYTES,
  parameter int unsigned RECORD_BYTES = bcfr_pkg::DEF_RECORD_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcfr_pkg::ADDR_W-1:0]     paddr,
  input  logic [bcfr_pkg::DATA_W-1:0]     pwdata,
  output logic [bcfr_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bcfr_pkg::OP_W-1:0]       opcode_i,
  input  logic [bcfr_pkg::BYTE_W-1:0]     rx_byte_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            store_valid_o,
  output logic                            store_target_o,
  output logic [bcfr_pkg::OFFSET_W-1:0]   store_offset_o,
  output logic [bcfr_pkg::BYTE_W-1:0]     store_byte_o,
  output logic                            frame_done_o,
  output logic [bcfr_pkg::BYTE_W-1:0]     frame_command_o,
  output logic [bcfr_pkg::KIND_W-1:0]     timeout_kind_o
);

  bcfr_pkg::cfg_t                cfg;
  bcfr_pkg::res_t                res, res_q;
  logic                          in_vld_q, in_vld_d;
  logic [bcfr_pkg::OP_W-1:0]     op_q;
  logic [bcfr_pkg::BYTE_W-1:0]   byte_q;
  logic                          out_vld_q, out_vld_d;
  logic                          advance;
  logic                          in_xfer;

  bcfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item leaves the input register once the result register is free
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign in_vld_d   = in_xfer | (in_vld_q & ~advance);
  assign out_vld_d  = advance | (out_vld_q & ~out_ready_i);

  bcfr_core #(
    .PAGE_BYTES   (PAGE_BYTES),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .opcode_i  (op_q),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= opcode_i;
      byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign store_valid_o   = res_q.store_valid;
  assign store_target_o  = res_q.store_target;
  assign store_offset_o  = res_q.store_offset;
  assign store_byte_o    = res_q.store_byte;
  assign frame_done_o    = res_q.frame_done;
  assign frame_command_o = res_q.frame_command;
  assign timeout_kind_o  = res_q.timeout_kind;

endmodule

[rtl/core/bcfr_checker.sv]
// Boot command frame receiver: port-level checker and its bind to the top.
// Depends on bcfr_pkg and boot_command_frame_receiver.
`timescale 1ns / 1ps

module bcfr_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic                            store_valid_o,
  input  logic                            store_target_o,
  input  logic [bcfr_pkg::OFFSET_W-1:0]   store_offset_o,
  input  logic [bcfr_pkg::BYTE_W-1:0]     store_byte_o,
  input  logic                            frame_done_o,
  input  logic [bcfr_pkg::BYTE_W-1:0]     frame_command_o,
  input  logic [bcfr_pkg::KIND_W-1:0]     timeout_kind_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_command_o)
      && $stable(store_byte_o) && $stable(timeout_kind_o))
    else $error("stalled result changed");

  // store fields are zero when nothing is stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !store_valid_o |-> store_offset_o == '0 && store_byte_o == '0
      && !store_target_o)
    else $error("store fields set without store_valid");

  // a result is a byte event or a tick event, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timeout_kind_o != bcfr_pkg::TO_NONE |-> !frame_done_o && !store_valid_o)
    else $error("timeout reported together with byte activity");

  // a stored payload byte belongs to a start or page frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_valid_o |->
      (store_target_o == bcfr_pkg::TGT_RECORD && frame_command_o == bcfr_pkg::CMD_START)
      || (store_target_o == bcfr_pkg::TGT_PAGE && frame_command_o == bcfr_pkg::CMD_PAGE))
    else $error("payload byte outside its frame");

endmodule

bind boot_command_frame_receiver bcfr_checker u_bcfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .store_valid_o   (store_valid_o),
  .store_target_o  (store_target_o),
  .store_offset_o  (store_offset_o),
  .store_byte_o    (store_byte_o),
  .frame_done_o    (frame_done_o),
  .frame_command_o (frame_command_o),
  .timeout_kind_o  (timeout_kind_o)
);

[verif/testbench.sv]
// Self-checking testbench for boot_command_frame_receiver: directed script, then
// random frames, checked against an in-bench frame predictor.
// Depends on bcfr_pkg and the boot_command_frame_receiver RTL.
`timescale 1ns / 1ps

module testbench;
  import bcfr_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused opcode, must be ignored
  localparam int unsigned QUIET_LIMIT = 2000;    // cycles without any transfer
  localparam int unsigned PHASE_ITEMS = 175;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;      // rx byte, or timeout value for ROW_CFG
    logic              reg_sel;
    logic              typed;     // want holds a hand-written expectation
    res_t              want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     opcode_i;
  logic [BYTE_W-1:0]   rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                store_valid_o;
  logic                store_target_o;
  logic [OFFSET_W-1:0] store_offset_o;
  logic [BYTE_W-1:0]   store_byte_o;
  logic                frame_done_o;
  logic [BYTE_W-1:0]   frame_command_o;
  logic [KIND_W-1:0]   timeout_kind_o;

  // predictor copy of the receiver
  logic [TO_W-1:0]     first_to;
  logic [TO_W-1:0]     idle_to;
  logic [LINK_W-1:0]   lnk_st;
  logic [BYTE_W-1:0]   cur_cmd;
  logic [LEFT_W-1:0]   left_cnt;
  logic [OFFSET_W-1:0] next_off;
  logic                tgt_sel;
  logic [TICK_W-1:0]   tick_cnt;
  logic [TICK_W-1:0]   deadline_cnt;

  res_t        pending_results[$];
  res_t        predicted;
  res_t        observed;
  res_t        oldest;
  res_t        typed_want;
  logic        typed_on;
  row_t        script_q[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int          stall_left;
  bit          calm;

  boot_command_frame_receiver dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Accepts a command byte; returns 1 when the frame completes on it.
  function automatic logic open_frame(logic [BYTE_W-1:0] c);
    cur_cmd = c;
    if (c == CMD_START || c == CMD_PAGE) begin
      tgt_sel  = (c == CMD_PAGE) ? TGT_PAGE : TGT_RECORD;
      left_cnt = (c == CMD_PAGE) ? LEFT_W'(DEF_PAGE_BYTES) : LEFT_W'(DEF_RECORD_BYTES);
      next_off = '0;
      lnk_st   = LS_PAYLOAD;
      return 1'b0;
    end
    lnk_st = LS_DONE;
    return 1'b1;
  endfunction

  function automatic res_t step_link(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    res_t r;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (lnk_st == LS_FIRST) begin
          if (b == CMD_VERSION) r.frame_done = open_frame(b);
        end else if (lnk_st == LS_READY) begin
          r.frame_done = open_frame(b);
        end else if (lnk_st == LS_PAYLOAD) begin
          if (left_cnt == '0) begin
            lnk_st = LS_DONE;
            r.frame_done = 1'b1;
          end else begin
            r.store_valid  = 1'b1;
            r.store_target = tgt_sel;
            r.store_offset = next_off;
            r.store_byte   = b;
            next_off = next_off + 1'b1;
            left_cnt = left_cnt - 1'b1;
            if (left_cnt == '0) begin
              lnk_st = LS_DONE;
              r.frame_done = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= deadline_cnt) r.timeout_kind = (lnk_st == LS_FIRST) ? TO_FIRST : TO_LATER;
      end
      OP_ACK: begin
        if (lnk_st == LS_DONE) begin
          lnk_st = LS_READY;
          if (tick_cnt > 32'hFFFF_FFFF - idle_to) deadline_cnt = '1;
          else deadline_cnt = tick_cnt + idle_to;
        end
      end
      default: ;
    endcase
    r.frame_command = cur_cmd;
    return r;
  endfunction

  function automatic res_t no_store(logic [BYTE_W-1:0] cmd, logic done, logic [KIND_W-1:0] kind);
    res_t r;
    r = '0;
    r.frame_done    = done;
    r.frame_command = cmd;
    r.timeout_kind  = kind;
    return r;
  endfunction

  function automatic row_t item_row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b, logic typed,
                                    res_t want);
    row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.data  = b;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic sel, logic [TO_W-1:0] v);
    row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.data    = v;
    return r;
  endfunction

  // Next item, shaped by where the link stands so most traffic forms real frames.
  task automatic pick_item(output logic [OP_W-1:0] op, output logic [BYTE_W-1:0] b);
    int r;
    r  = $urandom_range(0, 99);
    b  = $urandom_range(0, 255);
    op = OP_SPARE;
    case (lnk_st)
      LS_FIRST: begin
        op = (r < 70) ? OP_BYTE : OP_TICK;
        if (r < 40) b = CMD_VERSION;
      end
      LS_READY: begin
        if (r < 70) begin
          op = OP_BYTE;
          if (r < 45 || b == CMD_PAGE) begin
            b = CMD_START;
          end
        end else if (r < 85) op = OP_TICK;
        else if (r < 95) op = OP_ACK;
      end
      LS_PAYLOAD: begin
        if (r < 88) op = OP_BYTE;
        else if (r < 95) op = OP_TICK;
        else if (r < 98) op = OP_ACK;
      end
      default: begin
        if (r < 55) op = OP_ACK;
        else if (r < 80) op = OP_TICK;
        else if (r < 95) op = OP_BYTE;
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s: got 'h%0h, want 'h%0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // All driver tasks start and end at a falling edge.
  task automatic next_slot();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drive_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b, logic typed, res_t want);
    in_valid_i = 1'b1;
    opcode_i   = op;
    rx_byte_i  = b;
    typed_on   = typed;
    typed_want = want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [TO_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({sel, 2'b00});
    pwdata  = DATA_W'(v);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (sel == REG_FIRST_TO) begin
      first_to = v;
      if (lnk_st == LS_FIRST) deadline_cnt = TICK_W'(v);
    end else begin
      idle_to = v;
    end
  endtask

  task automatic read_reg(logic sel);
    logic [DATA_W-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_W'({sel, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    check_field(sel == REG_IDLE_TO ? "idle_timeout_ticks" : "first_timeout_ticks", got,
                DATA_W'(sel == REG_IDLE_TO ? idle_to : first_to));
  endtask

  task automatic random_run(int unsigned count);
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] b;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      next_slot();
      pick_item(op, b);
      drive_item(op, b, 1'b0, '0);
    end
  endtask

  // result side: random stalls, none begun while calm
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = step_link(opcode_i, rx_byte_i);
        pending_results.push_back(typed_on ? typed_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        observed = {store_valid_o, store_target_o, store_offset_o, store_byte_o,
                    frame_done_o, frame_command_o, timeout_kind_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", observed, '0);
        end else begin
          oldest = pending_results.pop_front();
          check_field("store_valid", observed.store_valid, oldest.store_valid);
          check_field("store_target", observed.store_target, oldest.store_target);
          check_field("store_offset", observed.store_offset, oldest.store_offset);
          check_field("store_byte", observed.store_byte, oldest.store_byte);
          check_field("frame_done", observed.frame_done, oldest.frame_done);
          check_field("frame_command", observed.frame_command, oldest.frame_command);
          check_field("timeout_kind", observed.timeout_kind, oldest.timeout_kind);
        end
      end
    end
  end

  // watchdog: any transfer on any port restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] b;
    row_t              row;
    int unsigned       n;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_BYTE;
    rx_byte_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    typed_on     = 1'b0;
    typed_want   = '0;
    calm         = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    first_to     = TIMEOUT_RESET;
    idle_to      = TIMEOUT_RESET;
    lnk_st       = LS_FIRST;
    cur_cmd      = '0;
    left_cnt     = '0;
    next_off     = '0;
    tgt_sel      = TGT_RECORD;
    tick_cnt     = '0;
    deadline_cnt = TICK_W'(TIMEOUT_RESET);

    // before the first command only the version request counts
    script_q.push_back(item_row(OP_BYTE, 8'h00, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_BYTE, 8'hFF, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_SPARE, 8'hFF, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_ACK, 8'h00, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    // first deadline reloads on write
    script_q.push_back(cfg_row(REG_FIRST_TO, 8'd0));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b1, no_store(8'h00, 1'b0, TO_FIRST)));
    script_q.push_back(cfg_row(REG_FIRST_TO, 8'd255));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b1, no_store(8'h00, 1'b0, TO_NONE)));
    script_q.push_back(cfg_row(REG_IDLE_TO, 8'd0));
    script_q.push_back(item_row(OP_BYTE, CMD_VERSION, 1'b1, no_store(CMD_VERSION, 1'b1, TO_NONE)));
    // byte while done is dropped; ack rearms with zero idle time
    script_q.push_back(item_row(OP_BYTE, CMD_START, 1'b1, no_store(CMD_VERSION, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_ACK, 8'h00, 1'b1, no_store(CMD_VERSION, 1'b0, TO_NONE)));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b1, no_store(CMD_VERSION, 1'b0, TO_LATER)));
    script_q.push_back(item_row(OP_ACK, 8'h00, 1'b0, '0));
    script_q.push_back(item_row(OP_BYTE, 8'hFF, 1'b1, no_store(8'hFF, 1'b1, TO_NONE)));
    script_q.push_back(cfg_row(REG_IDLE_TO, 8'd255));
    script_q.push_back(item_row(OP_ACK, 8'h00, 1'b0, '0));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b0, '0));
    // start record, interleaved with noise
    script_q.push_back(item_row(OP_BYTE, CMD_START, 1'b0, '0));
    script_q.push_back(item_row(OP_BYTE, 8'h00, 1'b0, '0));
    script_q.push_back(item_row(OP_TICK, 8'h00, 1'b0, '0));
    script_q.push_back(item_row(OP_BYTE, 8'hFF, 1'b0, '0));
    script_q.push_back(item_row(OP_SPARE, 8'h5A, 1'b0, '0));
    script_q.push_back(item_row(OP_ACK, 8'h00, 1'b0, '0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    read_reg(REG_FIRST_TO);
    read_reg(REG_IDLE_TO);

    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_sel, row.data);
      end else begin
        next_slot();
        drive_item(row.op, row.data, row.typed, row.want);
      end
    end
    settle();
    read_reg(REG_FIRST_TO);
    read_reg(REG_IDLE_TO);

    // finish the record with noise mixed in
    n = 0;
    while (lnk_st == LS_PAYLOAD) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      n++;
      next_slot();
      pick_item(op, b);
      drive_item(op, b, 1'b0, '0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_reg(REG_IDLE_TO, 8'd0);
        1: write_reg(REG_IDLE_TO, 8'd255);
        2: write_reg(REG_IDLE_TO, TO_W'($urandom_range(1, 30)));
        default: write_reg(REG_IDLE_TO, TO_W'($urandom_range(0, 255)));
      endcase
      write_reg(REG_FIRST_TO, TO_W'($urandom_range(0, 255)));
      read_reg(REG_FIRST_TO);
      read_reg(REG_IDLE_TO);
      random_run(PHASE_ITEMS);
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
